[rtl/core/c2dp_pkg.sv]
// Package for the complex to dB and phase converter.
// Holds widths, rotation and log constants and the sideband word types.
// No dependencies.
package c2dp_pkg;

  localparam int TABLE_STAGES        = 24;
  localparam int ROTATION_STAGES_DEF = 16;
  localparam int XW                  = 35;
  localparam int ZW                  = 26;
  localparam int NW                  = 31;
  localparam int FRAC_BITS           = 16;
  localparam int LW                  = 26;
  localparam int PW                  = 47;

  localparam logic [21:0] ATAN_Q16 [TABLE_STAGES] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
    22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
  };

  localparam logic signed [LW-1:0] LOG2_GAIN_Q16     = 26'sd47163;
  localparam logic signed [20:0]   DB_PER_OCTAVE_Q16 = 21'sd394566;
  localparam logic signed [ZW:0]   HALF_TURN_Q16     = 27'sd11796480;
  localparam logic signed [18:0]   WRAP_HI           = 19'sd23040;
  localparam logic signed [18:0]   FULL_TURN_Q7      = 19'sd46080;
  localparam logic [9:0]           EXP_BIAS          = 10'd158;
  localparam logic signed [15:0]   DB_MIN            = 16'sh8000;

  typedef struct packed {
    logic       last;
    logic       bad;
    logic       zero;
    logic       rneg;
    logic       ineg;
    logic [7:0] emax;
  } side_t;

  typedef struct packed {
    logic               last;
    logic               bad;
    logic               zero;
    logic [7:0]         emax;
    logic [5:0]         lead;
    logic signed [15:0] ang;
  } tail_t;

endpackage

[rtl/core/c2dp_in_if.sv]
// Input channel: one complex sample word with its valid/ready handshake.
// No dependencies.
interface c2dp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] real_word;
  logic [31:0] imag_word;
  logic        last_in;

  modport source (output valid, real_word, imag_word, last_in, input ready);
  modport sink (input valid, real_word, imag_word, last_in, output ready);
endinterface

[rtl/core/c2dp_out_if.sv]
// Output channel: one level/phase word with its valid/ready handshake.
// No dependencies.
interface c2dp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] level_db;
  logic signed [15:0] angle_deg;
  logic               zero_level;
  logic               bad_input;
  logic               last_out;

  modport source (output valid, level_db, angle_deg, zero_level, bad_input, last_out,
                  input ready);
  modport sink (input valid, level_db, angle_deg, zero_level, bad_input, last_out,
                output ready);
endinterface

[rtl/core/complex_to_db_and_phase.sv]
// Top level: complex float sample to level in dB and phase in degrees.
// Depends on c2dp_pkg, c2dp_in_if, c2dp_out_if, c2dp_front, c2dp_rot_cell,
// c2dp_sq_cell.
//
//   port      dir  word
//   in_s      in   real_word, imag_word, last_in
//   out_m     out  level_db, angle_deg, zero_level, bad_input, last_out
//   APB       in   swap_order at addresses 0 to 3
//
// One word a cycle unless the output stalls; the pipeline runs through the
// rotation cell chain and the 16 squaring cells of the log unit.
// Reset clears swap_order and all stage valid bits.
// A stalled output holds every stage; in_s.ready is low only while a result
// waits and out_m.ready is low.
module complex_to_db_and_phase #(
  parameter int ROTATION_STAGES = c2dp_pkg::ROTATION_STAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  c2dp_in_if.sink     in_s,
  c2dp_out_if.source  out_m,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int NS = (ROTATION_STAGES > c2dp_pkg::TABLE_STAGES) ?
                      c2dp_pkg::TABLE_STAGES : ROTATION_STAGES;
  localparam int XW = c2dp_pkg::XW;
  localparam int ZW = c2dp_pkg::ZW;
  localparam int NW = c2dp_pkg::NW;
  localparam int FB = c2dp_pkg::FRAC_BITS;
  localparam int LW = c2dp_pkg::LW;
  localparam int PW = c2dp_pkg::PW;

  logic swap_q;
  logic en;

  assign pready = 1'b1;
  assign prdata = {31'd0, swap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q <= 1'b0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      swap_q <= pwdata[0];
    end
  end

  logic                 rv [NS+1];
  logic signed [XW-1:0] rx [NS+1];
  logic signed [XW-1:0] ry [NS+1];
  logic signed [ZW-1:0] rz [NS+1];
  c2dp_pkg::side_t      rs [NS+1];

  assign in_s.ready = en;
  assign rz[0] = '0;

  c2dp_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_s.valid), .swap_i(swap_q),
    .real_word_i(in_s.real_word), .imag_word_i(in_s.imag_word),
    .last_i(in_s.last_in), .valid_o(rv[0]), .x_o(rx[0]), .y_o(ry[0]),
    .side_o(rs[0])
  );

  for (genvar g = 0; g < NS; g++) begin : g_rot
    c2dp_rot_cell #(.IDX(g)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .valid_i(rv[g]), .x_i(rx[g]), .y_i(ry[g]),
      .z_i(rz[g]), .side_i(rs[g]), .valid_o(rv[g+1]), .x_o(rx[g+1]),
      .y_o(ry[g+1]), .z_o(rz[g+1]), .side_o(rs[g+1])
    );
  end

  // leading one, phase mapping
  c2dp_pkg::side_t       sd;
  logic [XW-2:0]         mag;
  logic [5:0]            lead_d;
  logic signed [ZW:0]    ang;
  logic signed [ZW:0]    angr;
  logic signed [18:0]    aq, aw;
  c2dp_pkg::tail_t       t1_d;

  always_comb begin
    sd     = rs[NS];
    mag    = rx[NS][XW-2:0];
    lead_d = '0;
    for (int k = 0; k < XW-1; k++) begin
      if (mag[k]) lead_d = 6'(k);
    end
    unique case ({sd.rneg, sd.ineg})
      2'b00:   ang = 27'(rz[NS]);
      2'b10:   ang = c2dp_pkg::HALF_TURN_Q16 - 27'(rz[NS]);
      2'b11:   ang = 27'(rz[NS]) - c2dp_pkg::HALF_TURN_Q16;
      default: ang = -27'(rz[NS]);
    endcase
    angr = (ang + 27'sd256) >>> 9;
    aq   = angr[18:0];
    if (aq >= c2dp_pkg::WRAP_HI) begin
      aw = aq - c2dp_pkg::FULL_TURN_Q7;
    end else if (aq < -c2dp_pkg::WRAP_HI) begin
      aw = aq + c2dp_pkg::FULL_TURN_Q7;
    end else begin
      aw = aq;
    end
    t1_d.last = sd.last;
    t1_d.bad  = sd.bad;
    t1_d.zero = sd.zero;
    t1_d.emax = sd.emax;
    t1_d.lead = lead_d;
    t1_d.ang  = aw[15:0];
  end

  logic            v1_q, v2_q;
  logic [XW-2:0]   m1_q;
  c2dp_pkg::tail_t t1_q, t2_q;
  logic [NW-1:0]   n2_q;
  logic [NW-1:0]   n_norm;

  always_comb begin
    if (t1_q.lead <= 6'd30) begin
      n_norm = NW'(m1_q << (6'd30 - t1_q.lead));
    end else begin
      n_norm = NW'(m1_q >> (t1_q.lead - 6'd30));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= rv[NS];
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q <= mag;
      t1_q <= t1_d;
      n2_q <= n_norm;
      t2_q <= t1_q;
    end
  end

  logic            sv [FB+1];
  logic [NW-1:0]   sn [FB+1];
  logic [FB-1:0]   sf [FB+1];
  c2dp_pkg::tail_t st [FB+1];

  assign sv[0] = v2_q;
  assign sn[0] = n2_q;
  assign sf[0] = '0;
  assign st[0] = t2_q;

  for (genvar g = 0; g < FB; g++) begin : g_sq
    c2dp_sq_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .valid_i(sv[g]), .n_i(sn[g]), .frac_i(sf[g]),
      .tail_i(st[g]), .valid_o(sv[g+1]), .n_o(sn[g+1]), .frac_o(sf[g+1]),
      .tail_o(st[g+1])
    );
  end

  // level scaling
  c2dp_pkg::tail_t      tf;
  logic signed [9:0]    e2;
  logic signed [LW-1:0] l2;
  logic signed [PW-1:0] prod_d;
  logic                 v3_q, vo_q;
  logic signed [PW-1:0] prod_q;
  c2dp_pkg::tail_t      t3_q;
  logic signed [PW-1:0] dbr;
  logic signed [22:0]   dbv;
  logic signed [15:0]   db_sat;

  always_comb begin
    tf = st[FB];
    e2 = signed'({4'b0, tf.lead} + {2'b0, tf.emax} - c2dp_pkg::EXP_BIAS);
    l2 = LW'(e2) * 26'sd65536 + signed'(LW'({1'b0, sf[FB]}))
         - c2dp_pkg::LOG2_GAIN_Q16;
    prod_d = PW'(l2) * PW'(c2dp_pkg::DB_PER_OCTAVE_Q16);
  end

  always_comb begin
    dbr = (prod_q + 47'sd8388608) >>> 24;
    dbv = dbr[22:0];
    if (dbv > 23'sd32767) begin
      db_sat = 16'sd32767;
    end else if (dbv < -23'sd32768) begin
      db_sat = c2dp_pkg::DB_MIN;
    end else begin
      db_sat = dbv[15:0];
    end
  end

  assign en = !vo_q || out_m.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v3_q <= sv[FB];
      vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_d;
      t3_q   <= tf;
      out_m.last_out   <= t3_q.last;
      out_m.bad_input  <= t3_q.bad;
      out_m.zero_level <= !t3_q.bad && t3_q.zero;
      if (t3_q.bad) begin
        out_m.level_db  <= '0;
        out_m.angle_deg <= '0;
      end else if (t3_q.zero) begin
        out_m.level_db  <= c2dp_pkg::DB_MIN;
        out_m.angle_deg <= '0;
      end else begin
        out_m.level_db  <= db_sat;
        out_m.angle_deg <= t3_q.ang;
      end
    end
  end

  assign out_m.valid = vo_q;
endmodule

[rtl/core/c2dp_front.sv]
// Front stage: byte order, float decode and exponent alignment.
// Depends on c2dp_pkg.
module c2dp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic                          swap_i,
  input  logic [31:0]                   real_word_i,
  input  logic [31:0]                   imag_word_i,
  input  logic                          last_i,
  output logic                          valid_o,
  output logic signed [c2dp_pkg::XW-1:0] x_o,
  output logic signed [c2dp_pkg::XW-1:0] y_o,
  output c2dp_pkg::side_t               side_o
);
  logic [31:0] rw, iw;
  logic [7:0]  er, ei, ere, eie, d;
  logic [23:0] mr, mi;
  logic [31:0] ar, ai;
  logic [31:0] x_d, y_d;
  c2dp_pkg::side_t side_d;
  logic valid_q;

  always_comb begin
    rw = swap_i ? {real_word_i[7:0], real_word_i[15:8], real_word_i[23:16],
                   real_word_i[31:24]} : real_word_i;
    iw = swap_i ? {imag_word_i[7:0], imag_word_i[15:8], imag_word_i[23:16],
                   imag_word_i[31:24]} : imag_word_i;
    er  = rw[30:23];
    ei  = iw[30:23];
    mr  = {(er != 8'd0), rw[22:0]};
    mi  = {(ei != 8'd0), iw[22:0]};
    ere = (er == 8'd0) ? 8'd1 : er;
    eie = (ei == 8'd0) ? 8'd1 : ei;
    ar  = {mr, 8'd0};
    ai  = {mi, 8'd0};
    if (ere >= eie) begin
      d   = ere - eie;
      x_d = ar;
      y_d = ai >> d;
      side_d.emax = ere;
    end else begin
      d   = eie - ere;
      y_d = ai;
      x_d = ar >> d;
      side_d.emax = eie;
    end
    side_d.last = last_i;
    side_d.bad  = (er == 8'hFF) || (ei == 8'hFF);
    side_d.zero = (rw[30:0] == 31'd0) && (iw[30:0] == 31'd0);
    side_d.rneg = rw[31];
    side_d.ineg = iw[31];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= signed'({{(c2dp_pkg::XW-32){1'b0}}, x_d});
      y_o    <= signed'({{(c2dp_pkg::XW-32){1'b0}}, y_d});
      side_o <= side_d;
    end
  end

  assign valid_o = valid_q;
endmodule

[rtl/core/c2dp_rot_cell.sv]
// One vectoring rotation cell: shift-add step and angle accumulate.
// Depends on c2dp_pkg.
module c2dp_rot_cell #(
  parameter int IDX = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [c2dp_pkg::XW-1:0] x_i,
  input  logic signed [c2dp_pkg::XW-1:0] y_i,
  input  logic signed [c2dp_pkg::ZW-1:0] z_i,
  input  c2dp_pkg::side_t                side_i,
  output logic                           valid_o,
  output logic signed [c2dp_pkg::XW-1:0] x_o,
  output logic signed [c2dp_pkg::XW-1:0] y_o,
  output logic signed [c2dp_pkg::ZW-1:0] z_o,
  output c2dp_pkg::side_t                side_o
);
  localparam logic signed [c2dp_pkg::ZW-1:0] ATAN =
    signed'({{(c2dp_pkg::ZW-22){1'b0}}, c2dp_pkg::ATAN_Q16[IDX]});
  logic signed [c2dp_pkg::XW-1:0] xs, ys;
  logic valid_q;

  assign xs = x_i >>> IDX;
  assign ys = y_i >>> IDX;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      if (!y_i[c2dp_pkg::XW-1]) begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + ATAN;
      end else begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - ATAN;
      end
    end
  end

  assign valid_o = valid_q;
endmodule

[rtl/core/c2dp_sq_cell.sv]
// One log2 fraction cell: square, compare, renormalise, emit one bit.
// Depends on c2dp_pkg.
module c2dp_sq_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [c2dp_pkg::NW-1:0]              n_i,
  input  logic [c2dp_pkg::FRAC_BITS-1:0]       frac_i,
  input  c2dp_pkg::tail_t                      tail_i,
  output logic                                 valid_o,
  output logic [c2dp_pkg::NW-1:0]              n_o,
  output logic [c2dp_pkg::FRAC_BITS-1:0]       frac_o,
  output c2dp_pkg::tail_t                      tail_o
);
  logic [2*c2dp_pkg::NW-1:0] sq;
  logic [31:0]               sh;
  logic valid_q;

  assign sq = n_i * n_i;
  assign sh = sq[61:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tail_o <= tail_i;
      frac_o <= {frac_i[c2dp_pkg::FRAC_BITS-2:0], sh[31]};
      n_o    <= sh[31] ? sh[31:1] : sh[30:0];
    end
  end

  assign valid_o = valid_q;
endmodule

[tb/tb.sv]
// Testbench for complex_to_db_and_phase: streams complex float samples through
// the block under both byte orders and checks every level/phase word against
// an in-bench bit-exact predictor. Depends on c2dp_pkg, c2dp_in_if, c2dp_out_if.
`timescale 1ns / 1ps

module tb;

  localparam int  ROT_STAGES = 16;
  localparam int  LATENCY    = ROT_STAGES + 22;
  localparam int  LIMIT      = 400000;
  localparam logic [2:0] ADDR_SWAP   = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  typedef struct {
    logic [31:0] rw;
    logic [31:0] iw;
    logic        last;
  } sample_t;

  typedef struct {
    logic signed [15:0] level;
    logic signed [15:0] angle;
    logic               zero;
    logic               bad;
    logic               last;
  } level_phase_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  c2dp_in_if  in_if ();
  c2dp_out_if out_if ();

  complex_to_db_and_phase #(.ROTATION_STAGES(ROT_STAGES)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_s(in_if), .out_m(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sample_t      sample_q[$];
  level_phase_t level_phase_q[$];
  logic         swap_cfg;
  int           errs;
  int           cycles;
  int           gap_cnt, burst_cnt;
  int           hold_cnt, rx_mode;
  logic         taken;

  localparam longint ATAN_TBL [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0
  };

  function automatic logic [31:0] rev_bytes(logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic level_phase_t calc_level_phase(sample_t s, logic sw);
    logic [31:0] rw, iw;
    longint er, ei, mr, mi, emax, d;
    longint x, y, z, xo, ang, l2, dbv;
    longint unsigned m, n, frac;
    int p, i, k;
    level_phase_t r;
    rw = sw ? rev_bytes(s.rw) : s.rw;
    iw = sw ? rev_bytes(s.iw) : s.iw;
    r.level = 0; r.angle = 0; r.zero = 0; r.bad = 0; r.last = s.last;
    er = rw[30:23];
    ei = iw[30:23];
    if (er == 255 || ei == 255) begin
      r.bad = 1;
      return r;
    end
    mr = rw[22:0];
    mi = iw[22:0];
    if (mr == 0 && mi == 0 && er == 0 && ei == 0) begin
      r.level = 16'sh8000;
      r.zero  = 1;
      return r;
    end
    if (er != 0) mr = mr | 64'h800000; else er = 1;
    if (ei != 0) mi = mi | 64'h800000; else ei = 1;
    if (er >= ei) begin
      emax = er; d = er - ei;
      x = mr << 8;
      y = (d < 40) ? ((mi << 8) >>> d) : 0;
    end else begin
      emax = ei; d = ei - er;
      y = mi << 8;
      x = (d < 40) ? ((mr << 8) >>> d) : 0;
    end
    z = 0;
    for (i = 0; i < ROT_STAGES && i < 24; i++) begin
      xo = x;
      if (y >= 0) begin
        x = x + (y >>> i);
        y = y - (xo >>> i);
        z = z + ATAN_TBL[i];
      end else begin
        x = x - (y >>> i);
        y = y + (xo >>> i);
        z = z - ATAN_TBL[i];
      end
    end
    m = x;
    p = 0;
    for (k = 0; k < 63; k++)
      if (m[k]) p = k;
    if (p <= 30) n = m << (30 - p);
    else n = m >> (p - 30);
    frac = 0;
    for (k = 0; k < 16; k++) begin
      n = (n * n) >> 30;
      frac = frac << 1;
      if (n >= 64'h80000000) begin
        frac = frac | 1;
        n = n >> 1;
      end
    end
    l2 = (longint'(p) + emax - 158) * 65536 + longint'(frac) - 47163;
    dbv = (((l2 + 16777216) * 394566) + (64'sd1 << 23)) >>> 24;
    dbv = dbv - 394566;
    if (dbv > 32767) dbv = 32767;
    if (dbv < -32768) dbv = -32768;
    r.level = dbv[15:0];
    if (!rw[31] && !iw[31]) ang = z;
    else if (rw[31] && !iw[31]) ang = 11796480 - z;
    else if (rw[31] && iw[31]) ang = z - 11796480;
    else ang = -z;
    ang = ((ang + 33554432 + 256) >>> 9) - 65536;
    while (ang >= 23040) ang = ang - 46080;
    while (ang < -23040) ang = ang + 46080;
    r.angle = ang[15:0];
    return r;
  endfunction

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // accept input words and record what they should give
  always @(posedge clk_i) begin
    taken = 0;
    if (rst_ni && in_if.valid && in_if.ready && sample_q.size() > 0) begin
      level_phase_q = {level_phase_q,
                       calc_level_phase(sample_q.pop_front(), swap_cfg)};
      taken = 1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || taken)) begin
      if (gap_cnt > 0) begin
        in_if.valid <= 0;
        gap_cnt = gap_cnt - 1;
      end else if (sample_q.size() > 0) begin
        in_if.valid     <= 1;
        in_if.real_word <= sample_q[0].rw;
        in_if.imag_word <= sample_q[0].iw;
        in_if.last_in   <= sample_q[0].last;
        burst_cnt = burst_cnt - 1;
        if (burst_cnt <= 0) begin
          burst_cnt = $urandom_range(1, 24);
          gap_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end else begin
        in_if.valid <= 0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (cycles % 700 == 0) rx_mode = $urandom_range(0, 2);
    if (cycles == 150) hold_cnt = 300;
    if (hold_cnt > 0) begin
      out_if.ready <= 0;
      hold_cnt = hold_cnt - 1;
    end else if (rx_mode == 0) begin
      out_if.ready <= 1;
    end else if (rx_mode == 1) begin
      out_if.ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_if.ready <= (cycles % 5 < 2);
    end
  end

  always @(posedge clk_i) begin
    level_phase_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (level_phase_q.size() == 0) begin
        $display("%0t: unexpected word level=%0d angle=%0d", $time,
                 out_if.level_db, out_if.angle_deg);
        errs = errs + 1;
      end else begin
        e = level_phase_q.pop_front();
        if (out_if.level_db !== e.level || out_if.angle_deg !== e.angle ||
            out_if.zero_level !== e.zero || out_if.bad_input !== e.bad ||
            out_if.last_out !== e.last) begin
          $display("%0t: mismatch exp lvl=%0d ang=%0d z=%b b=%b l=%b got lvl=%0d ang=%0d z=%b b=%b l=%b",
                   $time, e.level, e.angle, e.zero, e.bad, e.last,
                   out_if.level_db, out_if.angle_deg, out_if.zero_level,
                   out_if.bad_input, out_if.last_out);
          errs = errs + 1;
        end
      end
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == ADDR_SWAP) swap_cfg = data[0];
  endtask

  task automatic settle();
    wait (sample_q.size() == 0 && level_phase_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
  endtask

  // words given in natural order; stored the way the block will see them
  task automatic add_sample(logic [31:0] rw, logic [31:0] iw, logic last);
    sample_t s;
    s.rw = swap_cfg ? rev_bytes(rw) : rw;
    s.iw = swap_cfg ? rev_bytes(iw) : iw;
    s.last = last;
    sample_q = {sample_q, s};
  endtask

  function automatic logic [31:0] rand_float();
    logic [7:0] ex;
    case ($urandom_range(0, 9))
      0: ex = $urandom_range(0, 255);
      1: ex = 0;
      2: ex = $urandom_range(200, 254);
      default: ex = $urandom_range(100, 160);
    endcase
    if (ex == 255 && $urandom_range(0, 3) != 0) ex = 254;
    return {1'($urandom), ex, 23'($urandom)};
  endfunction

  task automatic add_directed();
    add_sample(32'h00000000, 32'h00000000, 0);
    add_sample(32'h80000000, 32'h80000000, 1);
    add_sample(32'h7f800000, 32'h3f800000, 0);
    add_sample(32'h3f800000, 32'hff800000, 0);
    add_sample(32'h7fc00000, 32'h7fffffff, 1);
    add_sample(32'h3f800000, 32'h00000000, 0);
    add_sample(32'hbf800000, 32'h00000000, 0);
    add_sample(32'hbf800000, 32'h80000000, 0);
    add_sample(32'h00000000, 32'h3f800000, 0);
    add_sample(32'h00000000, 32'hbf800000, 0);
    add_sample(32'h3f800000, 32'h3f800000, 0);
    add_sample(32'hbf800000, 32'h3f800000, 0);
    add_sample(32'hbf800000, 32'hbf800000, 0);
    add_sample(32'h3f800000, 32'hbf800000, 1);
    add_sample(32'h7f7fffff, 32'h7f7fffff, 0);
    add_sample(32'hff7fffff, 32'h00000001, 0);
    add_sample(32'h00000001, 32'h00000001, 0);
    add_sample(32'h00000001, 32'h3f800000, 0);
    add_sample(32'h807fffff, 32'h00400000, 0);
    add_sample(32'h5f000000, 32'h5f000001, 1);
  endtask

  task automatic add_random(int cnt);
    sample_t s;
    for (int j = 0; j < cnt; j++) begin
      if ($urandom_range(0, 9) < 3) begin
        s.rw = $urandom;
        s.iw = $urandom;
        s.last = 1'($urandom);
        sample_q = {sample_q, s};
      end else begin
        add_sample(rand_float(), rand_float(), ($urandom_range(0, 7) == 0));
      end
    end
  endtask

  initial begin
    rst_ni = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_if.valid = 0; in_if.real_word = 0; in_if.imag_word = 0; in_if.last_in = 0;
    out_if.ready = 0;
    swap_cfg = 0; errs = 0; cycles = 0;
    gap_cnt = 0; burst_cnt = 1; hold_cnt = 0; rx_mode = 0; taken = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    apb_write(ADDR_SWAP, 32'd0);
    add_directed();
    add_random(260);
    settle();
    apb_write(ADDR_SWAP, 32'hffffffff);
    add_directed();
    add_random(260);
    settle();
    apb_write(ADDR_UNUSED, 32'h0);
    add_random(30);
    settle();
    apb_write(ADDR_SWAP, 32'h0);
    add_random(60);
    settle();
    if (errs == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
